// ===== rtl/core/pshc_pkg.sv =====
// ----------------------------------------------------------------------------
// Pipeline hazard and stall control package
// Types, opcodes, instruction field positions and register indexes shared by
// the hazard and stall control core.
// ----------------------------------------------------------------------------
package pshc_pkg;

  // Default width of the miss and branch delay counters.
  localparam int DELAY_BITS_DEF = 8;

  // Number of pipeline stages: IF, ID, EX, MEM, WB.
  localparam int NUM_STAGES = 5;

  // Word that stops the processor once it reaches writeback.
  localparam logic [31:0] HALT_WORD = 32'hfeedfeed;

  // Instruction field positions.
  localparam int OP_MSB = 31;
  localparam int OP_LSB = 26;
  localparam int RS_MSB = 25;
  localparam int RS_LSB = 21;
  localparam int RT_MSB = 20;
  localparam int RT_LSB = 16;

  // Opcodes.
  localparam logic [5:0] OPC_BEQ  = 6'h04;
  localparam logic [5:0] OPC_BNE  = 6'h05;
  localparam logic [5:0] OPC_BLEZ = 6'h06;
  localparam logic [5:0] OPC_BGTZ = 6'h07;
  localparam logic [5:0] OPC_LW   = 6'h23;
  localparam logic [5:0] OPC_LBU  = 6'h24;
  localparam logic [5:0] OPC_LHU  = 6'h25;
  localparam logic [5:0] OPC_SB   = 6'h28;
  localparam logic [5:0] OPC_SH   = 6'h29;
  localparam logic [5:0] OPC_SW   = 6'h2b;

  // Configuration register indexes.
  localparam logic [7:0] CFG_ICACHE_LAT = 8'd0;
  localparam logic [7:0] CFG_DCACHE_LAT = 8'd1;

  // Control action chosen for one tick.
  typedef enum logic [2:0] {
    ACT_HALT     = 3'd0,
    ACT_FETCH    = 3'd1,
    ACT_IMISS    = 3'd2,
    ACT_DMISS    = 3'd3,
    ACT_LOAD_USE = 3'd4,
    ACT_BRANCH   = 3'd5,
    ACT_OVERFLOW = 3'd6,
    ACT_ILLEGAL  = 3'd7
  } act_e;

  // Data access issued from the memory stage.
  typedef enum logic [1:0] {
    ACC_NONE  = 2'd0,
    ACC_READ  = 2'd1,
    ACC_WRITE = 2'd2
  } acc_e;

  // Flags of the most recently fetched instruction.
  typedef struct packed {
    logic halt;
    logic legal;
    logic ovf;
  } flags_t;

  // Pending squash requests for the decode and execute stages.
  typedef struct packed {
    logic ex;
    logic id;
  } squash_t;

  function automatic logic is_load(logic [5:0] op);
    return (op == OPC_LBU) || (op == OPC_LHU) || (op == OPC_LW);
  endfunction

  function automatic logic is_store(logic [5:0] op);
    return (op == OPC_SB) || (op == OPC_SH) || (op == OPC_SW);
  endfunction

  function automatic logic is_branch(logic [5:0] op);
    return (op == OPC_BLEZ) || (op == OPC_BGTZ) || (op == OPC_BEQ) || (op == OPC_BNE);
  endfunction

endpackage

// ===== rtl/core/pipeline_hazard_stall_control_core.sv =====
// ----------------------------------------------------------------------------
// Pipeline hazard and stall control core
// Picks one control action per processor tick, moves the five stage words,
// issues the memory-stage data access and keeps the miss and stall counters.
// ----------------------------------------------------------------------------
// Each tick's result is registered on its input transfer.
// Throughput: one tick per cycle while the result is taken; the state update is
// one pass of logic from the stage registers into themselves and the result register.
// Reset: asynchronous and active low; stages, counters and configuration clear,
// the latched legal flag is set, and no result is pending.
module pipeline_hazard_stall_control_core
  import pshc_pkg::*;
#(
  parameter int DELAY_BITS = DELAY_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  // Tick input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] fetch_word_i,
  input  logic [31:0] fetch_mem_addr_i,
  input  logic [31:0] fetch_seq_id_i,
  input  logic        fetch_overflow_i,
  input  logic        fetch_legal_i,
  input  logic        fetch_is_halt_i,
  input  logic        icache_hit_i,
  input  logic        dcache_hit_i,
  // Result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  control_action_o,
  output logic        fetch_taken_o,
  output logic [31:0] if_word_o,
  output logic [31:0] id_word_o,
  output logic [31:0] ex_word_o,
  output logic [31:0] mem_word_o,
  output logic [31:0] wb_word_o,
  output logic [1:0]  dcache_access_o,
  output logic [31:0] dcache_addr_o,
  output logic        halted_o,
  output logic [31:0] load_use_count_o
);

  localparam int SUM_W = ((DELAY_BITS > 8) ? DELAY_BITS : 8) + 1;
  localparam logic [SUM_W-1:0] DELAY_MAX = SUM_W'((1 << DELAY_BITS) - 1);

  // Saturating add of a latency onto a delay counter.
  function automatic logic [DELAY_BITS-1:0] sat_add(logic [DELAY_BITS-1:0] a,
                                                    logic [7:0] b);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b);
    return (s > DELAY_MAX) ? DELAY_MAX[DELAY_BITS-1:0] : s[DELAY_BITS-1:0];
  endfunction

  // Count down towards zero.
  function automatic logic [DELAY_BITS-1:0] dec(logic [DELAY_BITS-1:0] x);
    return (x != '0) ? x - DELAY_BITS'(1) : x;
  endfunction

  // State registers.
  logic [31:0]           word_q [NUM_STAGES];
  logic [31:0]           word_d [NUM_STAGES];
  logic [31:0]           addr_q [NUM_STAGES];
  logic [31:0]           addr_d [NUM_STAGES];
  logic [DELAY_BITS-1:0] iwait_q, iwait_d;
  logic [DELAY_BITS-1:0] dwait_q, dwait_d;
  logic [DELAY_BITS-1:0] bwait_q, bwait_d;
  logic [1:0]            ovf_nops_q, ovf_nops_d;
  logic                  ill_nops_q, ill_nops_d;
  squash_t               squash_q, squash_d;
  flags_t                flags_q, flags_d;
  logic [31:0]           seq_q, seq_d;
  logic [31:0]           last_br_q, last_br_d;
  logic [31:0]           stall_cnt_q, stall_cnt_d;
  logic [7:0]            ilat_q, dlat_q;

  // Result registers.
  logic                  out_valid_q;
  act_e                  act_q;
  logic                  taken_q;
  acc_e                  acc_q;
  logic [31:0]           daddr_q;

  // Combinational decision signals.
  act_e                  act;
  acc_e                  acc;
  logic [31:0]           daddr;
  logic                  in_xfer;
  logic [5:0]            id_op, ex_op, mem_op, new_op;
  logic [4:0]            id_rs, id_rt, ex_rt;
  logic                  br_cond, br_hit, lu_cond, count_stall;
  logic [DELAY_BITS-1:0] bwait_mid, iwait_dec, dwait_dec;
  logic [1:0]            ovf_nops_mid, ovf_nops_dec;
  logic                  ill_nops_mid;
  logic [2:0]            shift_from;
  logic                  fetch_now, zap_ex, zap_mem, do_access;

  assign in_xfer     = in_valid_i && in_ready_o;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;

  assign id_op = word_q[1][OP_MSB:OP_LSB];
  assign id_rs = word_q[1][RS_MSB:RS_LSB];
  assign id_rt = word_q[1][RT_MSB:RT_LSB];
  assign ex_op = word_q[2][OP_MSB:OP_LSB];
  assign ex_rt = word_q[2][RT_MSB:RT_LSB];
  assign new_op = fetch_word_i[OP_MSB:OP_LSB];

  // Hazard conditions seen in the decode and execute stages.
  assign br_cond = is_branch(id_op) && ((id_rs == ex_rt) || (id_rt == ex_rt)) &&
                   (ex_rt != '0) && (word_q[2] != '0) && (last_br_q != seq_q);
  assign br_hit  = ((id_op == OPC_BLEZ) || (id_op == OPC_BGTZ)) ? (id_rs == ex_rt) : 1'b1;
  assign lu_cond = is_load(ex_op) && ((ex_rt == id_rs) || (ex_rt == id_rt)) &&
                   (ex_rt != '0);

  // Action selection in priority order, with the counter updates it implies.
  always_comb begin
    act          = ACT_FETCH;
    count_stall  = 1'b0;
    bwait_mid    = bwait_q;
    last_br_d    = last_br_q;
    ovf_nops_mid = ovf_nops_q;
    ill_nops_mid = ill_nops_q;
    if (br_cond) begin
      act = ACT_BRANCH;
      if (br_hit) begin
        if (is_load(ex_op)) begin
          count_stall = 1'b1;
          bwait_mid   = DELAY_BITS'(2);
        end else begin
          bwait_mid = DELAY_BITS'(1);
        end
        last_br_d = seq_q;
      end
    end else if (lu_cond) begin
      act         = ACT_LOAD_USE;
      count_stall = 1'b1;
    end else if (flags_q.ovf || (ovf_nops_q != '0)) begin
      act = ACT_OVERFLOW;
      if (ovf_nops_q == '0) begin
        ovf_nops_mid = 2'd2;
      end
    end else if (!flags_q.legal || ill_nops_q) begin
      act = ACT_ILLEGAL;
      if (!ill_nops_q) begin
        ill_nops_mid = 1'b1;
      end
    end else if ((dwait_q == '0) && (bwait_q != '0)) begin
      act = ACT_BRANCH;
    end else if (((dwait_q == '0) && (iwait_q == '0) && (bwait_q == '0)) || squash_q.id) begin
      act = flags_q.halt ? ACT_HALT : ACT_FETCH;
    end else if ((dwait_q == '0) && (iwait_q != '0)) begin
      act = ACT_IMISS;
    end else begin
      act = ACT_DMISS;
      if (bwait_q != '0) begin
        bwait_mid = sat_add(bwait_q, 8'd1);
      end
    end
  end

  assign iwait_dec    = dec(iwait_q);
  assign dwait_dec    = dec(dwait_q);
  assign ovf_nops_dec = (ovf_nops_mid != '0) ? ovf_nops_mid - 2'd1 : ovf_nops_mid;

  // Per-action stage movement and bookkeeping.
  always_comb begin
    shift_from  = 3'd0;
    fetch_now   = 1'b0;
    zap_ex      = 1'b0;
    zap_mem     = 1'b0;
    do_access   = 1'b1;
    iwait_d     = iwait_dec;
    bwait_d     = dec(bwait_mid);
    flags_d     = flags_q;
    squash_d    = squash_q;
    ovf_nops_d  = ovf_nops_mid;
    ill_nops_d  = ill_nops_mid;
    seq_d       = seq_q;
    stall_cnt_d = (count_stall && (stall_cnt_q != '1)) ? stall_cnt_q + 32'd1 : stall_cnt_q;
    case (act)
      ACT_FETCH: begin
        shift_from = 3'd0;
        fetch_now  = 1'b1;
        if (squash_q.id) begin
          zap_ex      = 1'b1;
          squash_d.id = 1'b0;
        end else if (squash_q.ex) begin
          zap_mem     = 1'b1;
          squash_d.ex = 1'b0;
        end
        flags_d = '{halt: fetch_is_halt_i, legal: fetch_legal_i, ovf: fetch_overflow_i};
        seq_d   = fetch_seq_id_i;
        iwait_d = icache_hit_i ? '0 : sat_add('0, ilat_q);
      end
      ACT_IMISS: begin
        shift_from = 3'd1;
      end
      ACT_DMISS: begin
        shift_from = 3'd4;
        do_access  = 1'b0;
      end
      ACT_LOAD_USE, ACT_BRANCH: begin
        shift_from = 3'd2;
      end
      ACT_OVERFLOW: begin
        if (iwait_dec != '0) begin
          shift_from = 3'd1;
        end else begin
          shift_from  = 3'd0;
          ovf_nops_d  = ovf_nops_dec;
          flags_d.ovf = 1'b0;
          if (ovf_nops_dec == '0) begin
            squash_d.ex = 1'b1;
          end
        end
      end
      ACT_ILLEGAL: begin
        if (iwait_dec != '0) begin
          shift_from = 3'd1;
        end else begin
          shift_from    = 3'd0;
          ill_nops_d    = 1'b0;
          squash_d.id   = 1'b1;
          flags_d.legal = 1'b1;
        end
      end
      default: begin
        shift_from = 3'd0;
      end
    endcase
  end

  // Stage words: hold below the bubble point, insert a bubble, shift above it.
  always_comb begin
    if (shift_from == 3'd0) begin
      word_d[0] = '0;
      addr_d[0] = '0;
    end else begin
      word_d[0] = word_q[0];
      addr_d[0] = addr_q[0];
    end
    for (int i = 1; i < NUM_STAGES; i++) begin
      if (3'(i) < shift_from) begin
        word_d[i] = word_q[i];
        addr_d[i] = addr_q[i];
      end else if (3'(i) == shift_from) begin
        word_d[i] = '0;
        addr_d[i] = '0;
      end else begin
        word_d[i] = word_q[i-1];
        addr_d[i] = addr_q[i-1];
      end
    end
    if (fetch_now) begin
      word_d[0] = fetch_word_i;
      addr_d[0] = (is_load(new_op) || is_store(new_op)) ? fetch_mem_addr_i : '0;
    end
    if (zap_ex) begin
      word_d[2] = '0;
      addr_d[2] = '0;
    end
    if (zap_mem) begin
      word_d[3] = '0;
      addr_d[3] = '0;
    end
  end

  // Memory-stage data access on the updated stages.
  assign mem_op = word_d[3][OP_MSB:OP_LSB];

  always_comb begin
    acc     = ACC_NONE;
    daddr   = '0;
    dwait_d = dwait_dec;
    if (do_access && flags_d.legal) begin
      if (is_store(mem_op)) begin
        acc = ACC_WRITE;
      end else if (is_load(mem_op)) begin
        acc = ACC_READ;
      end
    end
    if (acc != ACC_NONE) begin
      daddr = addr_d[3];
      if (!dcache_hit_i) begin
        dwait_d = sat_add(dwait_dec, dlat_q);
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ilat_q <= '0;
      dlat_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ICACHE_LAT: ilat_q <= cfg_data_i;
        CFG_DCACHE_LAT: dlat_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline state, updated once per accepted tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        word_q[i] <= '0;
        addr_q[i] <= '0;
      end
      iwait_q     <= '0;
      dwait_q     <= '0;
      bwait_q     <= '0;
      ovf_nops_q  <= '0;
      ill_nops_q  <= 1'b0;
      squash_q    <= '0;
      flags_q     <= '{halt: 1'b0, legal: 1'b1, ovf: 1'b0};
      seq_q       <= '0;
      last_br_q   <= '0;
      stall_cnt_q <= '0;
    end else if (in_xfer) begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        word_q[i] <= word_d[i];
        addr_q[i] <= addr_d[i];
      end
      iwait_q     <= iwait_d;
      dwait_q     <= dwait_d;
      bwait_q     <= bwait_d;
      ovf_nops_q  <= ovf_nops_d;
      ill_nops_q  <= ill_nops_d;
      squash_q    <= squash_d;
      flags_q     <= flags_d;
      seq_q       <= seq_d;
      last_br_q   <= last_br_d;
      stall_cnt_q <= stall_cnt_d;
    end
  end

  // Result register; the stage words themselves are the stage outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      act_q   <= act;
      taken_q <= fetch_now;
      acc_q   <= acc;
      daddr_q <= daddr;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign control_action_o = act_q;
  assign fetch_taken_o    = taken_q;
  assign if_word_o        = word_q[0];
  assign id_word_o        = word_q[1];
  assign ex_word_o        = word_q[2];
  assign mem_word_o       = word_q[3];
  assign wb_word_o        = word_q[NUM_STAGES-1];
  assign dcache_access_o  = acc_q;
  assign dcache_addr_o    = daddr_q;
  assign halted_o         = (word_q[NUM_STAGES-1] == HALT_WORD);
  assign load_use_count_o = stall_cnt_q;

  // A consumed fetch word only ever comes with the fetch action.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fetch_taken_o |-> control_action_o == ACT_FETCH)
    else $error("fetch taken without fetch action");

  // A D-miss tick issues no data access.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (control_action_o == ACT_DMISS) |-> dcache_access_o == ACC_NONE)
    else $error("data access issued during D-miss wait");

  // No access means a zero address.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (dcache_access_o == ACC_NONE) |-> dcache_addr_o == '0)
    else $error("nonzero data address without access");

  // Stages move only on an input transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_xfer |=> $stable(wb_word_o) && $stable(load_use_count_o))
    else $error("pipeline state changed without a transfer");

endmodule

// ===== test/pipeline_hazard_stall_control_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pipeline hazard and stall control core testbench
// Drives one processor tick per input transfer and keeps its own model of the
// five stage words, the miss and branch delays and the load-use counter. Each
// result transfer is checked field by field against the oldest prediction.
// The run covers directed hazards, random instruction streams under several
// latency settings and idle patterns, and a final halt that drains the pipe.
// ----------------------------------------------------------------------------
module pipeline_hazard_stall_control_core_tb;
  import pshc_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD = 40;
  localparam int unsigned DLY_MAX = (1 << DELAY_BITS_DEF) - 1;

  // Stage positions in the pipeline.
  localparam int IF_S = 0;
  localparam int ID_S = 1;
  localparam int EX_S = 2;
  localparam int MEM_S = 3;
  localparam int WB_S = 4;

  // Opcodes that the block treats as plain ALU work.
  localparam logic [5:0] OPC_RTYPE = 6'h00;
  localparam logic [5:0] OPC_ADDI = 6'h08;
  localparam logic [5:0] OPC_ADDIU = 6'h09;
  localparam logic [5:0] OPC_ORI = 6'h0d;
  localparam logic [5:0] OPC_TOP = 6'h3f;

  typedef struct packed {
    logic [31:0] word;
    logic [31:0] mem_addr;
    logic [31:0] seq_id;
    logic        ovf;
    logic        legal;
    logic        halt;
    logic        ihit;
    logic        dhit;
  } tick_t;

  typedef struct packed {
    act_e        act;
    logic        taken;
    logic [31:0] if_w;
    logic [31:0] id_w;
    logic [31:0] ex_w;
    logic [31:0] mem_w;
    logic [31:0] wb_w;
    acc_e        acc;
    logic [31:0] daddr;
    logic        halted;
    logic [31:0] lu_count;
  } outcome_t;

  // Model of the hazard unit plus the queue of predicted results.
  class stall_ctrl_board;
    logic [7:0]  imiss_lat;
    logic [7:0]  dmiss_lat;
    logic [31:0] st_word[NUM_STAGES];
    logic [31:0] st_addr[NUM_STAGES];
    int unsigned imiss_left;
    int unsigned dmiss_left;
    int unsigned branch_left;
    int unsigned ovf_bubbles;
    int unsigned illegal_bubbles;
    squash_t     squash;
    flags_t      fetched;
    logic [31:0] fetched_seq;
    logic [31:0] branch_seq;
    logic [31:0] lu_stalls;
    outcome_t    expected[$];
    int          errors;
    bit          last_taken;
    bit          halt_seen;

    function new();
      imiss_lat = '0;
      dmiss_lat = '0;
      for (int i = 0; i < NUM_STAGES; i++) begin
        st_word[i] = '0;
        st_addr[i] = '0;
      end
      imiss_left = 0;
      dmiss_left = 0;
      branch_left = 0;
      ovf_bubbles = 0;
      illegal_bubbles = 0;
      squash = '0;
      fetched = '0;
      fetched.legal = 1'b1;
      fetched_seq = '0;
      branch_seq = '0;
      lu_stalls = '0;
      errors = 0;
      last_taken = 1'b0;
      halt_seen = 1'b0;
    endfunction

    function void set_latency(logic [7:0] idx, logic [7:0] val);
      case (idx)
        CFG_ICACHE_LAT: imiss_lat = val;
        CFG_DCACHE_LAT: dmiss_lat = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected.size();
    endfunction

    function int unsigned sat_delay(int unsigned v);
      return (v > DLY_MAX) ? DLY_MAX : v;
    endfunction

    function acc_e mem_kind(logic [5:0] op);
      case (op)
        OPC_LW, OPC_LBU, OPC_LHU: return ACC_READ;
        OPC_SB, OPC_SH, OPC_SW: return ACC_WRITE;
        default: return ACC_NONE;
      endcase
    endfunction

    function bit is_cond_branch(logic [5:0] op);
      return op inside {OPC_BEQ, OPC_BNE, OPC_BLEZ, OPC_BGTZ};
    endfunction

    function void bump_load_use();
      if (lu_stalls != '1) lu_stalls++;
    endfunction

    // Move stages below 'from' one step toward writeback; 'from' gets a bubble.
    function void shift_down(int from);
      for (int i = NUM_STAGES - 1; i > from; i--) begin
        st_word[i] = st_word[i-1];
        st_addr[i] = st_addr[i-1];
      end
      st_word[from] = '0;
      st_addr[from] = '0;
    endfunction

    // Memory-stage access; a miss extends the data cache wait.
    function void issue_access(logic dhit, output acc_e acc, output logic [31:0] addr);
      acc = ACC_NONE;
      addr = '0;
      if (fetched.legal) begin
        acc = mem_kind(st_word[MEM_S][OP_MSB:OP_LSB]);
        if (acc != ACC_NONE) begin
          addr = st_addr[MEM_S];
          if (!dhit) dmiss_left = sat_delay(dmiss_left + dmiss_lat);
        end
      end
    endfunction

    // Priority choice of the control action, then every nonzero wait counts down by one.
    function act_e pick_action();
      logic [5:0] id_op;
      logic [5:0] ex_op;
      logic [4:0] id_rs;
      logic [4:0] id_rt;
      logic [4:0] ex_rt;
      act_e       act;
      id_op = st_word[ID_S][OP_MSB:OP_LSB];
      id_rs = st_word[ID_S][RS_MSB:RS_LSB];
      id_rt = st_word[ID_S][RT_MSB:RT_LSB];
      ex_op = st_word[EX_S][OP_MSB:OP_LSB];
      ex_rt = st_word[EX_S][RT_MSB:RT_LSB];
      if (is_cond_branch(id_op) && (id_rs == ex_rt || id_rt == ex_rt) && ex_rt != 0 &&
          st_word[EX_S] != 0 && branch_seq != fetched_seq) begin
        // Compare-with-zero branches only read rs.
        if (!(id_op == OPC_BLEZ || id_op == OPC_BGTZ) || id_rs == ex_rt) begin
          if (mem_kind(ex_op) == ACC_READ) begin
            bump_load_use();
            branch_left = 2;
          end else begin
            branch_left = 1;
          end
          branch_seq = fetched_seq;
        end
        act = ACT_BRANCH;
      end else if (mem_kind(ex_op) == ACC_READ && (ex_rt == id_rs || ex_rt == id_rt) &&
                   ex_rt != 0) begin
        bump_load_use();
        act = ACT_LOAD_USE;
      end else if (fetched.ovf || ovf_bubbles > 0) begin
        act = ACT_OVERFLOW;
        if (ovf_bubbles == 0) ovf_bubbles = 2;
      end else if (!fetched.legal || illegal_bubbles > 0) begin
        act = ACT_ILLEGAL;
        if (illegal_bubbles == 0) illegal_bubbles = 1;
      end else if (dmiss_left == 0 && branch_left > 0) begin
        act = ACT_BRANCH;
      end else if ((dmiss_left == 0 && imiss_left == 0 && branch_left == 0) || squash.id) begin
        act = fetched.halt ? ACT_HALT : ACT_FETCH;
      end else if (dmiss_left == 0 && imiss_left > 0) begin
        act = ACT_IMISS;
      end else begin
        act = ACT_DMISS;
        if (branch_left > 0) branch_left = sat_delay(branch_left + 1);
      end
      if (imiss_left != 0) imiss_left--;
      if (dmiss_left != 0) dmiss_left--;
      if (branch_left != 0) branch_left--;
      return act;
    endfunction

    // Advance the model by one accepted tick and queue the predicted result.
    function void note_tick(tick_t t);
      outcome_t    o;
      acc_e        acc;
      logic [31:0] daddr;
      o = '0;
      acc = ACC_NONE;
      daddr = '0;
      o.act = pick_action();
      case (o.act)
        ACT_FETCH: begin
          shift_down(IF_S);
          if (squash.id) begin
            st_word[EX_S] = '0;
            st_addr[EX_S] = '0;
            squash.id = 1'b0;
          end else if (squash.ex) begin
            st_word[MEM_S] = '0;
            st_addr[MEM_S] = '0;
            squash.ex = 1'b0;
          end
          st_word[IF_S] = t.word;
          if (mem_kind(t.word[OP_MSB:OP_LSB]) != ACC_NONE) st_addr[IF_S] = t.mem_addr;
          fetched.ovf = t.ovf;
          fetched.legal = t.legal;
          fetched.halt = t.halt;
          fetched_seq = t.seq_id;
          o.taken = 1'b1;
          imiss_left = t.ihit ? 0 : imiss_lat;
        end
        ACT_IMISS: shift_down(ID_S);
        ACT_DMISS: begin
          st_word[WB_S] = '0;
          st_addr[WB_S] = '0;
        end
        ACT_LOAD_USE, ACT_BRANCH: shift_down(EX_S);
        ACT_OVERFLOW: begin
          if (imiss_left > 0) begin
            shift_down(ID_S);
          end else begin
            shift_down(IF_S);
            if (ovf_bubbles > 0) ovf_bubbles--;
            if (ovf_bubbles == 0) squash.ex = 1'b1;
            fetched.ovf = 1'b0;
          end
        end
        ACT_ILLEGAL: begin
          if (imiss_left > 0) begin
            shift_down(ID_S);
          end else begin
            shift_down(IF_S);
            if (illegal_bubbles > 0) illegal_bubbles--;
            if (illegal_bubbles == 0) squash.id = 1'b1;
            fetched.legal = 1'b1;
          end
        end
        default: shift_down(IF_S);
      endcase
      // Every action except the data miss wait issues the memory-stage access.
      if (o.act != ACT_DMISS) issue_access(t.dhit, acc, daddr);
      o.acc = acc;
      o.daddr = daddr;
      o.if_w = st_word[IF_S];
      o.id_w = st_word[ID_S];
      o.ex_w = st_word[EX_S];
      o.mem_w = st_word[MEM_S];
      o.wb_w = st_word[WB_S];
      o.halted = (st_word[WB_S] == HALT_WORD);
      o.lu_count = lu_stalls;
      last_taken = o.taken;
      if (o.halted) halt_seen = 1'b1;
      expected.push_back(o);
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %h, got %h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(outcome_t got);
      outcome_t want;
      if (expected.size() == 0) begin
        $error("result transfer with no tick outstanding, action %0d", got.act);
        errors++;
        return;
      end
      want = expected.pop_front();
      compare("control_action", want.act, got.act);
      compare("fetch_taken", want.taken, got.taken);
      compare("if_word", want.if_w, got.if_w);
      compare("id_word", want.id_w, got.id_w);
      compare("ex_word", want.ex_w, got.ex_w);
      compare("mem_word", want.mem_w, got.mem_w);
      compare("wb_word", want.wb_w, got.wb_w);
      compare("dcache_access", want.acc, got.acc);
      compare("dcache_addr", want.daddr, got.daddr);
      compare("halted", want.halted, got.halted);
      compare("load_use_count", want.lu_count, got.lu_count);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i;
  logic [7:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] fetch_word_i;
  logic [31:0] fetch_mem_addr_i;
  logic [31:0] fetch_seq_id_i;
  logic        fetch_overflow_i;
  logic        fetch_legal_i;
  logic        fetch_is_halt_i;
  logic        icache_hit_i;
  logic        dcache_hit_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  control_action_o;
  logic        fetch_taken_o;
  logic [31:0] if_word_o;
  logic [31:0] id_word_o;
  logic [31:0] ex_word_o;
  logic [31:0] mem_word_o;
  logic [31:0] wb_word_o;
  logic [1:0]  dcache_access_o;
  logic [31:0] dcache_addr_o;
  logic        halted_o;
  logic [31:0] load_use_count_o;

  stall_ctrl_board board;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_reqs;
  logic [31:0] seq_next;

  // Random phases: latencies, idle pattern and hit rates per phase.
  localparam int NUM_SEGS = 5;
  int         seg_items[NUM_SEGS] = '{550, 250, 250, 450, 350};
  logic [7:0] seg_ilat[NUM_SEGS] = '{8'd5, 8'd0, 8'd255, 8'd1, 8'd3};
  logic [7:0] seg_dlat[NUM_SEGS] = '{8'd7, 8'd255, 8'd0, 8'd2, 8'd1};
  int         seg_send_idle[NUM_SEGS] = '{26, 26, 64, 64, 0};
  int         seg_recv_idle[NUM_SEGS] = '{64, 64, 26, 26, 0};
  int         seg_hit_pct[NUM_SEGS] = '{85, 97, 97, 85, 85};
  bit         seg_long_hold[NUM_SEGS] = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1};

  logic [5:0] load_ops[3] = '{OPC_LW, OPC_LBU, OPC_LHU};
  logic [5:0] store_ops[3] = '{OPC_SB, OPC_SH, OPC_SW};
  logic [5:0] branch_ops[4] = '{OPC_BEQ, OPC_BNE, OPC_BLEZ, OPC_BGTZ};

  pipeline_hazard_stall_control_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .fetch_word_i     (fetch_word_i),
    .fetch_mem_addr_i (fetch_mem_addr_i),
    .fetch_seq_id_i   (fetch_seq_id_i),
    .fetch_overflow_i (fetch_overflow_i),
    .fetch_legal_i    (fetch_legal_i),
    .fetch_is_halt_i  (fetch_is_halt_i),
    .icache_hit_i     (icache_hit_i),
    .dcache_hit_i     (dcache_hit_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .control_action_o (control_action_o),
    .fetch_taken_o    (fetch_taken_o),
    .if_word_o        (if_word_o),
    .id_word_o        (id_word_o),
    .ex_word_o        (ex_word_o),
    .mem_word_o       (mem_word_o),
    .wb_word_o        (wb_word_o),
    .dcache_access_o  (dcache_access_o),
    .dcache_addr_o    (dcache_addr_o),
    .halted_o         (halted_o),
    .load_use_count_o (load_use_count_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic logic [31:0] instr(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                        logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic tick_t mk(logic [31:0] word, logic [31:0] maddr, logic [31:0] seq,
                               logic ovf, logic legal, logic halt, logic ihit, logic dhit);
    tick_t t;
    t.word = word;
    t.mem_addr = maddr;
    t.seq_id = seq;
    t.ovf = ovf;
    t.legal = legal;
    t.halt = halt;
    t.ihit = ihit;
    t.dhit = dhit;
    return t;
  endfunction

  // Registers mostly come from a small set so that hazards are frequent.
  function automatic logic [4:0] pick_reg();
    return ($urandom_range(99) < 80) ? 5'($urandom_range(3)) : 5'($urandom_range(31));
  endfunction

  function automatic tick_t random_tick(int hit_pct);
    int          pick;
    logic [5:0]  op;
    logic [31:0] seq;
    pick = $urandom_range(99);
    if (pick < 25) op = load_ops[$urandom_range(2)];
    else if (pick < 45) op = store_ops[$urandom_range(2)];
    else if (pick < 65) op = branch_ops[$urandom_range(3)];
    else op = 6'($urandom);
    // Sequence numbers mostly advance; repeats exercise the once-only branch check.
    pick = $urandom_range(99);
    if (pick < 85) begin
      seq = seq_next;
      seq_next++;
    end else if (pick < 95) begin
      seq = seq_next - 1;
    end else begin
      seq = $urandom;
    end
    return mk(instr(op, pick_reg(), pick_reg(), 16'($urandom)), $urandom, seq,
              $urandom_range(99) < 4, $urandom_range(99) >= 5, 1'b0,
              $urandom_range(99) < hit_pct, $urandom_range(99) < hit_pct);
  endfunction

  // Offer one tick, holding it until the transfer; called and left at a falling edge.
  task automatic send_tick(tick_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    fetch_word_i <= t.word;
    fetch_mem_addr_i <= t.mem_addr;
    fetch_seq_id_i <= t.seq_id;
    fetch_overflow_i <= t.ovf;
    fetch_legal_i <= t.legal;
    fetch_is_halt_i <= t.halt;
    icache_hit_i <= t.ihit;
    dcache_hit_i <= t.dhit;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_tick(t);
    @(negedge clk_i);
  endtask

  // Write both miss latencies back to back while the block is idle.
  task automatic program_latencies(logic [7:0] ilat, logic [7:0] dlat);
    logic [7:0] idx[2];
    logic [7:0] val[2];
    idx[0] = CFG_ICACHE_LAT;
    idx[1] = CFG_DCACHE_LAT;
    val[0] = ilat;
    val[1] = dlat;
    for (int r = 0; r < 2; r++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[r];
      cfg_data_i <= val[r];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      board.set_latency(idx[r], val[r]);
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Result side: random backpressure, plus one long hold per request.
  initial begin : result_ready
    int holds_done;
    holds_done = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_reqs != holds_done) begin
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk_i);
        holds_done++;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Check every result transfer against the oldest prediction.
  always @(posedge clk_i) begin : result_check
    outcome_t seen;
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen.act = act_e'(control_action_o);
      seen.taken = fetch_taken_o;
      seen.if_w = if_word_o;
      seen.id_w = id_word_o;
      seen.ex_w = ex_word_o;
      seen.mem_w = mem_word_o;
      seen.wb_w = wb_word_o;
      seen.acc = acc_e'(dcache_access_o);
      seen.daddr = dcache_addr_o;
      seen.halted = halted_o;
      seen.lu_count = load_use_count_o;
      board.check_result(seen);
    end
  end

  // End the run if no transfer of any kind happens for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("pipeline_hazard_stall_control_core regression: fail");
    $finish;
  end

  initial begin : stimulus
    int n;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    fetch_word_i = '0;
    fetch_mem_addr_i = '0;
    fetch_seq_id_i = '0;
    fetch_overflow_i = 1'b0;
    fetch_legal_i = 1'b1;
    fetch_is_halt_i = 1'b0;
    icache_hit_i = 1'b1;
    dcache_hit_i = 1'b1;
    hold_reqs = 0;
    send_idle_pct = seg_send_idle[0];
    recv_idle_pct = seg_recv_idle[0];
    board = new();
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    program_latencies(8'd2, 8'd3);

    // Directed hazards: load-use, branch on load and on ALU result, the
    // compare-with-zero rs rule, a repeated sequence number, overflow,
    // illegal encoding, both cache misses and all-zero / all-one fields.
    send_tick(mk(instr(OPC_LW, 1, 2, 16'h0010), 32'hffff_fffc, 1, 0, 1, 0, 1, 1));
    send_tick(mk(instr(OPC_RTYPE, 2, 3, 16'h0020), 0, 2, 0, 1, 0, 1, 1));
    send_tick(mk(instr(OPC_SW, 4, 2, 16'h0004), 32'h0000_1000, 3, 0, 1, 0, 1, 0));
    send_tick(mk(instr(OPC_LHU, 0, 5, 16'h0002), 32'h8000_0000, 4, 0, 1, 0, 1, 1));
    send_tick(mk(instr(OPC_BEQ, 5, 6, 16'hfffe), 0, 5, 0, 1, 0, 1, 1));
    send_tick(mk(instr(OPC_ADDI, 7, 8, 16'h0001), 0, 6, 0, 1, 0, 1, 1));
    send_tick(mk(instr(OPC_BLEZ, 8, 0, 16'h0003), 0, 7, 0, 1, 0, 1, 1));
    send_tick(mk(instr(OPC_ADDIU, 1, 9, 16'h0000), 0, 8, 0, 1, 0, 1, 1));
    send_tick(mk(instr(OPC_BGTZ, 3, 9, 16'h0000), 0, 9, 0, 1, 0, 1, 1));
    send_tick(mk(instr(OPC_LBU, 2, 10, 16'h0000), 32'h0000_0003, 10, 0, 1, 0, 1, 1));
    send_tick(mk(instr(OPC_BNE, 10, 10, 16'h0000), 0, 10, 0, 1, 0, 1, 1));
    send_tick(mk(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1, 1, 0, 1, 1));
    send_tick(mk(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 0, 0, 0, 1, 1));
    send_tick(mk(instr(OPC_SB, 1, 1, 16'h0000), 32'h5555_aaaa, 13, 0, 1, 0, 0, 1));
    send_tick(mk(instr(OPC_SH, 2, 3, 16'h0000), 32'haaaa_5555, 14, 0, 1, 0, 1, 0));
    send_tick(mk(instr(OPC_RTYPE, 0, 0, 16'h0000), 0, 15, 0, 1, 0, 1, 1));
    send_tick(mk(instr(OPC_LW, 3, 4, 16'h0000), 32'h1234_5678, 16, 0, 1, 0, 1, 0));
    send_tick(mk(instr(OPC_BEQ, 4, 0, 16'h0000), 0, 17, 0, 1, 0, 1, 1));
    send_tick(mk(instr(OPC_ORI, 4, 4, 16'h0000), 0, 18, 1, 1, 0, 1, 1));
    send_tick(mk(instr(OPC_TOP, 31, 31, 16'hffff), 0, 19, 0, 0, 0, 1, 1));
    seq_next = 20;

    // Random phases; the sender pauses until all results are back between them.
    for (int s = 0; s < NUM_SEGS; s++) begin
      in_valid_i <= 1'b0;
      while (board.pending() != 0) @(negedge clk_i);
      send_idle_pct = seg_send_idle[s];
      recv_idle_pct = seg_recv_idle[s];
      program_latencies(seg_ilat[s], seg_dlat[s]);
      if (seg_long_hold[s]) hold_reqs++;
      for (n = 0; n < seg_items[s]; n++) send_tick(random_tick(seg_hit_pct[s]));
    end

    // Offer the halt word until it is fetched, then keep ticking while it drains.
    board.last_taken = 1'b0;
    while (!board.last_taken) send_tick(mk(HALT_WORD, 0, seq_next, 0, 1, 1, 1, 1));
    n = 0;
    while (!board.halt_seen && n < 600) begin
      send_tick(random_tick(90));
      n++;
    end
    repeat (10) send_tick(random_tick(90));
    in_valid_i <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("pipeline_hazard_stall_control_core regression: pass");
    end else begin
      $display("pipeline_hazard_stall_control_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== pipeline_hazard_stall_control_core.f =====
rtl/core/pshc_pkg.sv
rtl/core/pipeline_hazard_stall_control_core.sv
test/pipeline_hazard_stall_control_core_tb.sv
